[rtl/spdc_pkg.sv]
// ----------------------------------------------------------------------------
// spdc_pkg
// types, register codes and reset values shared by the pump duty controller
// ----------------------------------------------------------------------------
package spdc_pkg;

   localparam int unsigned TIME_W   = 32;
   localparam int unsigned HOLD_W   = 16;
   localparam int unsigned HOUR_W   = 5;
   localparam int unsigned MINUTE_W = 17;
   localparam int unsigned CSR_IDX_W = 3;

   // minutes = (ms >> 5) / 1875, done as an exact reciprocal multiply
   localparam int unsigned DIV_PRE_SHIFT = 5;
   localparam int unsigned DIV_IN_W      = TIME_W - DIV_PRE_SHIFT;
   localparam int unsigned DIV_MAGIC_W   = 28;
   localparam int unsigned DIV_SHIFT     = 38;
   localparam int unsigned DIV_PROD_W    = DIV_IN_W + DIV_MAGIC_W;
   localparam logic [DIV_MAGIC_W-1:0] DIV_MAGIC = 28'd146601551;

   localparam logic [TIME_W-1:0] ON_MIN_RESET    = 32'd60000;
   localparam logic [TIME_W-1:0] ON_MAX_RESET    = 32'd600000;
   localparam logic [TIME_W-1:0] OFF_RESET       = 32'd300000;
   localparam logic [TIME_W-1:0] STEP_RESET      = 32'd10000;
   localparam logic [HOLD_W-1:0] HOLDOFF_RESET   = 16'd10;
   localparam logic [HOUR_W-1:0] NIGHT_START_RST = 5'd20;
   localparam logic [HOUR_W-1:0] NIGHT_END_RST   = 5'd6;

   localparam logic OP_UPDATE   = 1'b0;
   localparam logic OP_OVERRIDE = 1'b1;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_ON_MIN      = 3'd0,
      REG_ON_MAX      = 3'd1,
      REG_OFF         = 3'd2,
      REG_STEP        = 3'd3,
      REG_HOLDOFF     = 3'd4,
      REG_NIGHT_START = 3'd5,
      REG_NIGHT_END   = 3'd6
   } reg_index_type;

   typedef struct packed {
      logic [TIME_W-1:0] on_min;
      logic [TIME_W-1:0] on_max;
      logic [TIME_W-1:0] off_ms;
      logic [TIME_W-1:0] step;
      logic [HOLD_W-1:0] holdoff;
      logic [HOUR_W-1:0] night_start;
      logic [HOUR_W-1:0] night_end;
   } cfg_type;

   typedef struct packed {
      logic              pump;
      logic [TIME_W-1:0] interval;
      logic [HOLD_W-1:0] holdoff;
      logic [TIME_W-1:0] last_ms;
      logic              toggled;
      logic              override;
   } state_type;

   typedef struct packed {
      logic              op;
      logic [TIME_W-1:0] now_ms;
      logic [HOUR_W-1:0] hour;
      logic              bright;
      logic              full;
      logic              critical;
      logic              ov_en;
      logic              ov_on;
   } item_type;

   typedef struct packed {
      logic              pump_on;
      logic              adjust_levels;
      logic              adjust_brighter;
      logic              override_active;
      logic [TIME_W-1:0] since_ms;
   } res_type;

endpackage

[rtl/spdc_decide.sv]
// ----------------------------------------------------------------------------
// spdc_decide
// mode selection, interval adaptation and relay decision for one item
// ----------------------------------------------------------------------------
module spdc_decide (
   input  spdc_pkg::cfg_type   cfg,
   input  spdc_pkg::state_type state,
   input  spdc_pkg::item_type  item,
   output spdc_pkg::state_type state_next,
   output spdc_pkg::res_type   res
);

   logic [spdc_pkg::TIME_W:0]   grow_sum;
   logic [spdc_pkg::TIME_W-1:0] grow_sat;
   logic [spdc_pkg::TIME_W-1:0] shrink_sat;
   logic [spdc_pkg::TIME_W-1:0] grow_iv;
   logic [spdc_pkg::TIME_W-1:0] shrink_iv;
   logic [spdc_pkg::TIME_W-1:0] since;
   logic                        night;
   logic                        standby;
   logic                        adjust;
   logic                        brighter;

   function automatic logic [spdc_pkg::TIME_W-1:0] clamp_iv(
      input logic [spdc_pkg::TIME_W-1:0] v,
      input logic [spdc_pkg::TIME_W-1:0] lo,
      input logic [spdc_pkg::TIME_W-1:0] hi
   );
      logic [spdc_pkg::TIME_W-1:0] r;
      priority if (v < lo) begin
         r = lo;
      end else if (v > hi) begin
         r = hi;
      end else begin
         r = v;
      end
      return r;
   endfunction

   always_comb begin
      grow_sum   = {1'b0, state.interval} + {1'b0, cfg.step};
      grow_sat   = grow_sum[spdc_pkg::TIME_W] ? '1 : grow_sum[spdc_pkg::TIME_W-1:0];
      shrink_sat = (state.interval < cfg.step) ? '0 : state.interval - cfg.step;
      grow_iv    = clamp_iv(grow_sat, cfg.on_min, cfg.on_max);
      shrink_iv  = clamp_iv(shrink_sat, cfg.on_min, cfg.on_max);
      since      = item.now_ms - state.last_ms;
      night      = (item.hour <= cfg.night_end) || (item.hour >= cfg.night_start);
   end

   always_comb begin
      state_next = state;
      standby    = 1'b0;
      adjust     = 1'b0;
      brighter   = 1'b0;
      if (item.op == spdc_pkg::OP_OVERRIDE) begin
         state_next.override = item.ov_en;
         if (!item.ov_en) begin
            state_next.pump = item.ov_on & ~item.critical;
         end
      end else if (!state.override) begin
         priority if (night) begin
            standby             = 1'b1;
            state_next.interval = cfg.on_min;
         end else if (item.bright) begin
            standby = 1'b0;
         end else if (item.full) begin
            state_next.holdoff  = cfg.holdoff;
            state_next.interval = grow_iv;
            adjust              = 1'b1;
            brighter            = 1'b1;
         end else if (state.holdoff != '0) begin
            state_next.holdoff = state.holdoff - 16'd1;
         end else begin
            standby             = 1'b1;
            adjust              = 1'b1;
            state_next.interval = shrink_iv;
         end

         if (standby) begin
            state_next.holdoff = '0;
            priority if (!state.toggled
                         || (state.pump && since > state_next.interval)) begin
               state_next.pump    = 1'b0;
               state_next.last_ms = item.now_ms;
               state_next.toggled = 1'b1;
            end else if (!state.pump && since > cfg.off_ms) begin
               state_next.pump    = ~item.critical;
               state_next.last_ms = item.now_ms;
               state_next.toggled = 1'b1;
            end else begin
               state_next.pump = state.pump;
            end
         end else begin
            state_next.pump    = ~item.critical;
            state_next.last_ms = '0;
            state_next.toggled = 1'b0;
         end
      end
   end

   always_comb begin
      res.pump_on         = state_next.pump;
      res.adjust_levels   = adjust;
      res.adjust_brighter = brighter;
      res.override_active = state_next.override;
      res.since_ms        = item.now_ms - state_next.last_ms;
   end

endmodule

[rtl/spdc_min_div.sv]
// ----------------------------------------------------------------------------
// spdc_min_div
// milliseconds to whole minutes by exact reciprocal multiplication
// ----------------------------------------------------------------------------
module spdc_min_div (
   input  logic [spdc_pkg::TIME_W-1:0]   since_ms,
   output logic [spdc_pkg::MINUTE_W-1:0] minutes
);

   logic [spdc_pkg::DIV_IN_W-1:0]   scaled;
   logic [spdc_pkg::DIV_PROD_W-1:0] prod;

   always_comb begin
      scaled  = since_ms[spdc_pkg::TIME_W-1:spdc_pkg::DIV_PRE_SHIFT];
      prod    = spdc_pkg::DIV_PROD_W'(scaled) * spdc_pkg::DIV_PROD_W'(spdc_pkg::DIV_MAGIC);
      minutes = prod[spdc_pkg::DIV_SHIFT +: spdc_pkg::MINUTE_W];
   end

endmodule

[rtl/solar_pump_duty_controller.sv]
// ----------------------------------------------------------------------------
// solar_pump_duty_controller
// pump relay controller: continuous or standby duty cycle with override
// ----------------------------------------------------------------------------
// usage
// - req channel carries update items (op 0) and override commands (op 1);
//   every accepted item yields exactly one item on the rsp channel, in order
// - csr port writes the seven control registers; write only while idle
// - the decision and all state updates happen in the transfer cycle of the
//   item; the minute count is formed from a registered time difference in a
//   second stage, and the result is registered again in the rsp stage
// - one item per cycle sustained while rsp_ready holds; the combinational
//   state loop (mode choice, interval clamp, toggle compare) sets that rate
// - a stalled rsp side keeps its result; one more item is held in the
//   middle stage, after which req_ready drops until rsp_ready returns
// - reset clears both stages, puts the registers at their default values,
//   the pump off, the on-interval at its minimum and override released
// ----------------------------------------------------------------------------
module solar_pump_duty_controller (
   input  logic                               clock,
   input  logic                               reset,

   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic                               req_op,
   input  logic [spdc_pkg::TIME_W-1:0]        req_now_ms,
   input  logic [spdc_pkg::HOUR_W-1:0]        req_hour_of_day,
   input  logic                               req_is_bright,
   input  logic                               req_battery_full,
   input  logic                               req_battery_critical,
   input  logic                               req_override_enable,
   input  logic                               req_override_pump_on,

   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic                               rsp_pump_on,
   output logic                               rsp_adjust_levels,
   output logic                               rsp_adjust_brighter,
   output logic                               rsp_override_active,
   output logic [spdc_pkg::MINUTE_W-1:0]      rsp_elapsed_minutes,

   input  logic                               csr_we,
   input  logic [spdc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [spdc_pkg::TIME_W-1:0]        csr_wdata
);

   spdc_pkg::cfg_type   cfg_ff;
   spdc_pkg::cfg_type   cfg_in;
   spdc_pkg::state_type state_ff;
   spdc_pkg::state_type state_in;
   spdc_pkg::state_type state_next;
   spdc_pkg::item_type  item;
   spdc_pkg::res_type   res;
   spdc_pkg::res_type   mid_ff;
   spdc_pkg::res_type   mid_in;
   logic                mid_valid_ff;
   logic                mid_valid_in;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   logic                rsp_pump_ff;
   logic                rsp_pump_in;
   logic                rsp_adjust_ff;
   logic                rsp_adjust_in;
   logic                rsp_brighter_ff;
   logic                rsp_brighter_in;
   logic                rsp_override_ff;
   logic                rsp_override_in;
   logic [spdc_pkg::MINUTE_W-1:0] rsp_minutes_ff;
   logic [spdc_pkg::MINUTE_W-1:0] rsp_minutes_in;
   logic [spdc_pkg::MINUTE_W-1:0] minutes;
   logic                rsp_take;
   logic                req_xfer;

   // control registers
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            spdc_pkg::REG_ON_MIN:      cfg_in.on_min      = csr_wdata;
            spdc_pkg::REG_ON_MAX:      cfg_in.on_max      = csr_wdata;
            spdc_pkg::REG_OFF:         cfg_in.off_ms      = csr_wdata;
            spdc_pkg::REG_STEP:        cfg_in.step        = csr_wdata;
            spdc_pkg::REG_HOLDOFF:     cfg_in.holdoff     = csr_wdata[spdc_pkg::HOLD_W-1:0];
            spdc_pkg::REG_NIGHT_START: cfg_in.night_start = csr_wdata[spdc_pkg::HOUR_W-1:0];
            spdc_pkg::REG_NIGHT_END:   cfg_in.night_end   = csr_wdata[spdc_pkg::HOUR_W-1:0];
            default:                   cfg_in = cfg_ff;
         endcase
      end
   end

   // handshake
   always_comb begin
      rsp_take     = ~rsp_valid_ff | rsp_ready;
      req_ready    = ~mid_valid_ff | rsp_take;
      req_xfer     = req_valid & req_ready;
      mid_valid_in = req_xfer | (mid_valid_ff & ~rsp_take);
      rsp_valid_in = rsp_take ? mid_valid_ff : 1'b1;
   end

   always_comb begin
      item.op       = req_op;
      item.now_ms   = req_now_ms;
      item.hour     = req_hour_of_day;
      item.bright   = req_is_bright;
      item.full     = req_battery_full;
      item.critical = req_battery_critical;
      item.ov_en    = req_override_enable;
      item.ov_on    = req_override_pump_on;
   end

   spdc_decide u_decide (
      .cfg        (cfg_ff),
      .state      (state_ff),
      .item       (item),
      .state_next (state_next),
      .res        (res)
   );

   spdc_min_div u_min_div (
      .since_ms (mid_ff.since_ms),
      .minutes  (minutes)
   );

   always_comb begin
      state_in        = req_xfer ? state_next : state_ff;
      mid_in          = (mid_valid_ff & ~rsp_take) ? mid_ff : res;
      rsp_pump_in     = rsp_take ? mid_ff.pump_on         : rsp_pump_ff;
      rsp_adjust_in   = rsp_take ? mid_ff.adjust_levels   : rsp_adjust_ff;
      rsp_brighter_in = rsp_take ? mid_ff.adjust_brighter : rsp_brighter_ff;
      rsp_override_in = rsp_take ? mid_ff.override_active : rsp_override_ff;
      rsp_minutes_in  = rsp_take ? minutes                : rsp_minutes_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.on_min      <= spdc_pkg::ON_MIN_RESET;
         cfg_ff.on_max      <= spdc_pkg::ON_MAX_RESET;
         cfg_ff.off_ms      <= spdc_pkg::OFF_RESET;
         cfg_ff.step        <= spdc_pkg::STEP_RESET;
         cfg_ff.holdoff     <= spdc_pkg::HOLDOFF_RESET;
         cfg_ff.night_start <= spdc_pkg::NIGHT_START_RST;
         cfg_ff.night_end   <= spdc_pkg::NIGHT_END_RST;
         state_ff.pump      <= 1'b0;
         state_ff.interval  <= spdc_pkg::ON_MIN_RESET;
         state_ff.holdoff   <= '0;
         state_ff.last_ms   <= '0;
         state_ff.toggled   <= 1'b0;
         state_ff.override  <= 1'b0;
         mid_valid_ff       <= 1'b0;
         rsp_valid_ff       <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         state_ff     <= state_in;
         mid_valid_ff <= mid_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      mid_ff          <= mid_in;
      rsp_pump_ff     <= rsp_pump_in;
      rsp_adjust_ff   <= rsp_adjust_in;
      rsp_brighter_ff <= rsp_brighter_in;
      rsp_override_ff <= rsp_override_in;
      rsp_minutes_ff  <= rsp_minutes_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_pump_on         = rsp_pump_ff;
   assign rsp_adjust_levels   = rsp_adjust_ff;
   assign rsp_adjust_brighter = rsp_brighter_ff;
   assign rsp_override_active = rsp_override_ff;
   assign rsp_elapsed_minutes = rsp_minutes_ff;

endmodule

[bench/solar_pump_duty_controller_tb.sv]
// ----------------------------------------------------------------------------
// solar_pump_duty_controller_tb
// self-checking bench: predictor, directed and random items, stalls on both
// channels, a long response stall and a full drain
// ----------------------------------------------------------------------------
module solar_pump_duty_controller_tb;

   localparam int unsigned CYCLE_LIMIT = 200000;
   localparam logic [spdc_pkg::TIME_W-1:0] MS_PER_MINUTE = 32'd60000;
   localparam logic [spdc_pkg::CSR_IDX_W-1:0] REG_UNUSED = 3'd7;

   typedef struct packed {
      logic                          pump_on;
      logic                          adjust_levels;
      logic                          adjust_brighter;
      logic                          override_active;
      logic [spdc_pkg::MINUTE_W-1:0] elapsed_minutes;
   } pump_result_type;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_valid = 1'b0;
   logic                           req_ready;
   logic                           req_op = spdc_pkg::OP_UPDATE;
   logic [spdc_pkg::TIME_W-1:0]    req_now_ms = '0;
   logic [spdc_pkg::HOUR_W-1:0]    req_hour_of_day = '0;
   logic                           req_is_bright = 1'b0;
   logic                           req_battery_full = 1'b0;
   logic                           req_battery_critical = 1'b0;
   logic                           req_override_enable = 1'b0;
   logic                           req_override_pump_on = 1'b0;
   logic                           rsp_valid;
   logic                           rsp_ready = 1'b0;
   logic                           rsp_pump_on;
   logic                           rsp_adjust_levels;
   logic                           rsp_adjust_brighter;
   logic                           rsp_override_active;
   logic [spdc_pkg::MINUTE_W-1:0]  rsp_elapsed_minutes;
   logic                           csr_we = 1'b0;
   logic [spdc_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [spdc_pkg::TIME_W-1:0]    csr_wdata = '0;

   // predictor state
   spdc_pkg::cfg_type           m_cfg;
   logic                        m_pump;
   logic [spdc_pkg::TIME_W-1:0] m_interval;
   logic [spdc_pkg::HOLD_W-1:0] m_holdoff;
   logic [spdc_pkg::TIME_W-1:0] m_last_ms;
   logic                        m_toggled;
   logic                        m_override;

   pump_result_type             expected_pump_q[$];
   int                          mismatch_count = 0;
   int                          cycle_count = 0;
   int                          send_idle_pct = 0;
   int                          rcv_idle_pct = 0;
   int                          rsp_hold_cycles = 0;
   logic [spdc_pkg::TIME_W-1:0] sim_ms = '0;

   solar_pump_duty_controller uut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_op               (req_op),
      .req_now_ms           (req_now_ms),
      .req_hour_of_day      (req_hour_of_day),
      .req_is_bright        (req_is_bright),
      .req_battery_full     (req_battery_full),
      .req_battery_critical (req_battery_critical),
      .req_override_enable  (req_override_enable),
      .req_override_pump_on (req_override_pump_on),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_pump_on          (rsp_pump_on),
      .rsp_adjust_levels    (rsp_adjust_levels),
      .rsp_adjust_brighter  (rsp_adjust_brighter),
      .rsp_override_active  (rsp_override_active),
      .rsp_elapsed_minutes  (rsp_elapsed_minutes),
      .csr_we               (csr_we),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata)
   );

   always #4 clock = ~clock;

   function automatic pump_result_type predict_pump(input spdc_pkg::item_type it);
      pump_result_type             res;
      logic                        adjust;
      logic                        brighter;
      logic                        standby;
      logic [spdc_pkg::TIME_W-1:0] v;
      logic [spdc_pkg::TIME_W-1:0] since;
      logic [spdc_pkg::TIME_W-1:0] diff;
      logic [spdc_pkg::TIME_W-1:0] quot;
      adjust = 1'b0;
      brighter = 1'b0;
      if (it.op == spdc_pkg::OP_OVERRIDE) begin
         m_override = it.ov_en;
         if (!m_override)
            m_pump = it.ov_on && !it.critical;
      end else if (!m_override) begin
         standby = 1'b0;
         if (it.hour <= m_cfg.night_end || it.hour >= m_cfg.night_start) begin
            standby = 1'b1;
            m_interval = m_cfg.on_min;
         end else if (it.bright) begin
            standby = 1'b0;
         end else if (it.full) begin
            m_holdoff = m_cfg.holdoff;
            adjust = 1'b1;
            brighter = 1'b1;
         end else if (m_holdoff != '0) begin
            m_holdoff = m_holdoff - 16'd1;
         end else begin
            standby = 1'b1;
            adjust = 1'b1;
         end

         if (adjust) begin
            v = m_interval;
            if (brighter)
               v = (v > 32'hFFFF_FFFF - m_cfg.step) ? 32'hFFFF_FFFF : v + m_cfg.step;
            else
               v = (v < m_cfg.step) ? 32'd0 : v - m_cfg.step;
            if (v < m_cfg.on_min)
               v = m_cfg.on_min;
            else if (v > m_cfg.on_max)
               v = m_cfg.on_max;
            m_interval = v;
         end

         if (standby) begin
            since = it.now_ms - m_last_ms;
            m_holdoff = '0;
            if (!m_toggled || (m_pump && since > m_interval)) begin
               m_pump = 1'b0;
               m_last_ms = it.now_ms;
               m_toggled = 1'b1;
            end else if (!m_pump && since > m_cfg.off_ms) begin
               m_pump = !it.critical;
               m_last_ms = it.now_ms;
               m_toggled = 1'b1;
            end
         end else begin
            m_pump = !it.critical;
            m_last_ms = '0;
            m_toggled = 1'b0;
         end
      end
      diff = it.now_ms - m_last_ms;
      quot = diff / MS_PER_MINUTE;
      res.pump_on = m_pump;
      res.adjust_levels = adjust;
      res.adjust_brighter = brighter;
      res.override_active = m_override;
      res.elapsed_minutes = quot[spdc_pkg::MINUTE_W-1:0];
      return res;
   endfunction

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         mismatch_count++;
      end
   endfunction

   // response side stalls
   always @(posedge clock) begin
      if (rsp_hold_cycles > 0) begin
         rsp_hold_cycles--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rcv_idle_pct);
      end
   end

   // outputs are stable at the falling edge, so the coming transfer is known here
   always @(negedge clock) begin
      pump_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_pump_q.size() == 0) begin
            $display("%0t: unexpected transfer, expected none, actual pump %0b minutes %0d",
                     $time, rsp_pump_on, rsp_elapsed_minutes);
            mismatch_count++;
         end else begin
            want = expected_pump_q.pop_front();
            check_field("pump_on", 32'(want.pump_on), 32'(rsp_pump_on));
            check_field("adjust_levels", 32'(want.adjust_levels), 32'(rsp_adjust_levels));
            check_field("adjust_brighter", 32'(want.adjust_brighter),
                        32'(rsp_adjust_brighter));
            check_field("override_active", 32'(want.override_active),
                        32'(rsp_override_active));
            check_field("elapsed_minutes", 32'(want.elapsed_minutes),
                        32'(rsp_elapsed_minutes));
         end
      end
   end

   task automatic send_item(input spdc_pkg::item_type it);
      logic accepted;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_op <= it.op;
      req_now_ms <= it.now_ms;
      req_hour_of_day <= it.hour;
      req_is_bright <= it.bright;
      req_battery_full <= it.full;
      req_battery_critical <= it.critical;
      req_override_enable <= it.ov_en;
      req_override_pump_on <= it.ov_on;
      accepted = 1'b0;
      while (!accepted) begin
         @(negedge clock);
         accepted = req_ready;
         if (accepted)
            expected_pump_q.push_back(predict_pump(it));
         @(posedge clock);
      end
   endtask

   task automatic send_fields(input logic op, input logic [spdc_pkg::TIME_W-1:0] now,
                              input logic [spdc_pkg::HOUR_W-1:0] hour, input logic bright,
                              input logic full, input logic critical,
                              input logic ov_en, input logic ov_on);
      spdc_pkg::item_type it;
      it = '{op: op, now_ms: now, hour: hour, bright: bright, full: full,
             critical: critical, ov_en: ov_en, ov_on: ov_on};
      send_item(it);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (expected_pump_q.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input logic [spdc_pkg::CSR_IDX_W-1:0] idx,
                            input logic [spdc_pkg::TIME_W-1:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      unique case (idx)
         spdc_pkg::REG_ON_MIN:      m_cfg.on_min = val;
         spdc_pkg::REG_ON_MAX:      m_cfg.on_max = val;
         spdc_pkg::REG_OFF:         m_cfg.off_ms = val;
         spdc_pkg::REG_STEP:        m_cfg.step = val;
         spdc_pkg::REG_HOLDOFF:     m_cfg.holdoff = val[spdc_pkg::HOLD_W-1:0];
         spdc_pkg::REG_NIGHT_START: m_cfg.night_start = val[spdc_pkg::HOUR_W-1:0];
         spdc_pkg::REG_NIGHT_END:   m_cfg.night_end = val[spdc_pkg::HOUR_W-1:0];
         default: begin
         end
      endcase
   endtask

   // raw values so that bits above a register's width are also driven
   task automatic load_config(input logic [spdc_pkg::TIME_W-1:0] on_min,
                              input logic [spdc_pkg::TIME_W-1:0] on_max,
                              input logic [spdc_pkg::TIME_W-1:0] off_ms,
                              input logic [spdc_pkg::TIME_W-1:0] step,
                              input logic [spdc_pkg::TIME_W-1:0] holdoff,
                              input logic [spdc_pkg::TIME_W-1:0] night_start,
                              input logic [spdc_pkg::TIME_W-1:0] night_end);
      drain_results();
      write_reg(spdc_pkg::REG_ON_MIN, on_min);
      write_reg(spdc_pkg::REG_ON_MAX, on_max);
      write_reg(spdc_pkg::REG_OFF, off_ms);
      write_reg(spdc_pkg::REG_STEP, step);
      write_reg(spdc_pkg::REG_HOLDOFF, holdoff);
      write_reg(spdc_pkg::REG_NIGHT_START, night_start);
      write_reg(spdc_pkg::REG_NIGHT_END, night_end);
      write_reg(REG_UNUSED, $urandom);
      csr_we <= 1'b0;
   endtask

   task automatic random_traffic_item(output spdc_pkg::item_type it);
      int          pick;
      int          lo;
      int          hi;
      logic [31:0] hour_raw;
      pick = $urandom_range(99);
      if (pick < 85)
         sim_ms = sim_ms + $urandom_range(0, 4000);
      else if (pick < 95)
         sim_ms = sim_ms + $urandom_range(0, 300000);
      else
         sim_ms = $urandom;
      it.now_ms = sim_ms;
      lo = int'(m_cfg.night_end) + 1;
      hi = int'(m_cfg.night_start) - 1;
      if ($urandom_range(99) < 15 || lo > hi)
         hour_raw = $urandom_range(0, 31);
      else
         hour_raw = $urandom_range(lo, hi);
      it.hour = hour_raw[spdc_pkg::HOUR_W-1:0];
      it.op = ($urandom_range(99) < 8) ? spdc_pkg::OP_OVERRIDE : spdc_pkg::OP_UPDATE;
      it.bright = ($urandom_range(99) < 25);
      it.full = ($urandom_range(99) < 12);
      it.critical = ($urandom_range(99) < 15);
      it.ov_en = ($urandom_range(99) < 35);
      it.ov_on = ($urandom_range(1) == 1);
   endtask

   task automatic test_reset_defaults();
      send_fields(spdc_pkg::OP_UPDATE, 32'd0, 5'd12, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
      send_fields(spdc_pkg::OP_UPDATE, 32'd400000, 5'd12, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
      send_fields(spdc_pkg::OP_UPDATE, 32'd470001, 5'd12, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1);
      send_fields(spdc_pkg::OP_UPDATE, 32'd900000, 5'd12, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0);
      send_fields(spdc_pkg::OP_UPDATE, 32'd950000, 5'd3, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0);
      send_fields(spdc_pkg::OP_UPDATE, 32'd960000, 5'd20, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
      send_fields(spdc_pkg::OP_UPDATE, 32'd970000, 5'd31, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
      send_fields(spdc_pkg::OP_UPDATE, 32'd980000, 5'd6, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
      send_fields(spdc_pkg::OP_UPDATE, 32'd990000, 5'd19, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
      send_fields(spdc_pkg::OP_UPDATE, 32'd1000000, 5'd7, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0);
      send_fields(spdc_pkg::OP_UPDATE, 32'd1010000, 5'd12, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0);
      send_fields(spdc_pkg::OP_UPDATE, 32'd1020000, 5'd12, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
      send_fields(spdc_pkg::OP_OVERRIDE, 32'd1030000, 5'd12, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1);
      send_fields(spdc_pkg::OP_UPDATE, 32'd1040000, 5'd12, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
      send_fields(spdc_pkg::OP_OVERRIDE, 32'd1050000, 5'd12, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1);
      send_fields(spdc_pkg::OP_OVERRIDE, 32'd1060000, 5'd12, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1);
      send_fields(spdc_pkg::OP_UPDATE, 32'hFFFF_FFFF, 5'd12, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
      send_fields(spdc_pkg::OP_OVERRIDE, 32'd0, 5'd31, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0);
   endtask

   task automatic test_config_extremes();
      // min above max, saturating step, widest hold-off
      load_config(32'hFFFF_FFFF, 32'd0, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                  32'hFFFF_FFF7, 32'hFFFF_FFE0);
      send_fields(spdc_pkg::OP_UPDATE, 32'd5000, 5'd12, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0);
      send_fields(spdc_pkg::OP_UPDATE, 32'd6000, 5'd12, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
      send_fields(spdc_pkg::OP_UPDATE, 32'd7000, 5'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
      send_fields(spdc_pkg::OP_UPDATE, 32'd8000, 5'd23, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
      load_config(32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 32'd0, 32'd0, 32'd23);
      send_fields(spdc_pkg::OP_UPDATE, 32'h8000_0000, 5'd12, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
      send_fields(spdc_pkg::OP_UPDATE, 32'h7FFF_FFFF, 5'd0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0);
   endtask

   task automatic test_random_traffic(input int count, input int send_pct, input int rcv_pct);
      logic [spdc_pkg::TIME_W-1:0] on_min;
      spdc_pkg::item_type          it;
      int                          done;
      on_min = $urandom_range(500, 5000);
      load_config(on_min, on_min + $urandom_range(0, 20000), $urandom_range(0, 8000),
                  $urandom_range(0, 3000), $urandom_range(0, 6),
                  $urandom_range(17, 23), $urandom_range(0, 7));
      send_idle_pct = send_pct;
      rcv_idle_pct = rcv_pct;
      sim_ms = $urandom;
      done = 0;
      while (done < count) begin
         random_traffic_item(it);
         send_item(it);
         done++;
      end
   endtask

   task automatic test_backpressure();
      spdc_pkg::item_type it;
      send_idle_pct = 0;
      rcv_idle_pct = 0;
      rsp_hold_cycles = 60;
      repeat (30) begin
         random_traffic_item(it);
         send_item(it);
      end
      drain_results();
      repeat (20) begin
         random_traffic_item(it);
         send_item(it);
      end
   endtask

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Verification failed");
      $finish;
   end

   initial begin
      m_cfg = '{on_min: spdc_pkg::ON_MIN_RESET, on_max: spdc_pkg::ON_MAX_RESET,
                off_ms: spdc_pkg::OFF_RESET, step: spdc_pkg::STEP_RESET,
                holdoff: spdc_pkg::HOLDOFF_RESET,
                night_start: spdc_pkg::NIGHT_START_RST,
                night_end: spdc_pkg::NIGHT_END_RST};
      m_pump = 1'b0;
      m_interval = spdc_pkg::ON_MIN_RESET;
      m_holdoff = '0;
      m_last_ms = '0;
      m_toggled = 1'b0;
      m_override = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_defaults();
      test_config_extremes();
      test_random_traffic(200, 34, 77);
      test_random_traffic(200, 77, 34);
      test_random_traffic(200, 0, 0);
      test_backpressure();
      drain_results();
      if (mismatch_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
